// ===== rtl/uart_rx_fifo_with_error_counts_defines.svh =====
// Assertion macros used by the UART receive FIFO controller.
`ifndef UART_RX_FIFO_WITH_ERROR_COUNTS_DEFINES_SVH
`define UART_RX_FIFO_WITH_ERROR_COUNTS_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define URXF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define URXF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/urxf_pkg.sv =====
// Package with the shared types and constants of the UART receive FIFO.
`default_nettype none
package urxf_pkg;

	// Item kinds carried in the slave-side tuser bit.
	localparam logic MODE_RX   = 1'b0;
	localparam logic MODE_READ = 1'b1;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 72;
	localparam int CNT_W     = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push;       // write the byte into the ring
		logic drop;       // ring full, count the lost byte
		logic err_inc;    // count a line error
		logic pop;        // read the oldest byte and advance
		logic load_now;   // load a result without ring data
		logic load_pop;   // load a result with the popped byte
	} urxf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
	} urxf_stat_t;

endpackage
`default_nettype wire

// ===== rtl/urxf_dp.sv =====
// Datapath of the UART receive FIFO: ring memory, pointers, counters, result register.
`default_nettype none
module urxf_dp #(
	parameter int DEPTH = 512
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  urxf_pkg::urxf_cmd_t    cmd,
	input  wire  [7:0]                   rx_byte,
	output urxf_pkg::urxf_stat_t         stat,
	output logic                         read_valid,
	output logic [7:0]                   read_data,
	output logic [urxf_pkg::CNT_W-1:0]   overflow_total,
	output logic [urxf_pkg::CNT_W-1:0]   error_total
);

	localparam int PW = $clog2(DEPTH);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [7:0]                 ring_q [DEPTH];
	logic [7:0]                 rd_byte_q;
	logic [PW-1:0]              wr_ptr_q;
	logic [PW-1:0]              rd_ptr_q;
	logic [PW-1:0]              wr_next;
	logic [PW-1:0]              rd_next;
	logic [urxf_pkg::CNT_W-1:0] drop_cnt_q;
	logic [urxf_pkg::CNT_W-1:0] err_cnt_q;
	logic [urxf_pkg::CNT_W-1:0] drop_cnt_next;
	logic [urxf_pkg::CNT_W-1:0] err_cnt_next;
	logic                       read_valid_q;
	logic [7:0]                 read_data_q;
	logic [urxf_pkg::CNT_W-1:0] overflow_total_q;
	logic [urxf_pkg::CNT_W-1:0] error_total_q;

	// Pointers wrap at DEPTH, which need not be a power of two.
	assign wr_next = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;

	assign stat.full  = (wr_next == rd_ptr_q);
	assign stat.empty = (wr_ptr_q == rd_ptr_q);

	assign drop_cnt_next = drop_cnt_q + urxf_pkg::CNT_W'(cmd.drop);
	assign err_cnt_next  = err_cnt_q + urxf_pkg::CNT_W'(cmd.err_inc);

	// Ring storage with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ring_q[wr_ptr_q] <= rx_byte;
		end
		if (cmd.pop) begin
			rd_byte_q <= ring_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			drop_cnt_q <= '0;
			err_cnt_q  <= '0;
		end else begin
			if (cmd.push) begin
				wr_ptr_q <= wr_next;
			end
			if (cmd.pop) begin
				rd_ptr_q <= rd_next;
			end
			drop_cnt_q <= drop_cnt_next;
			err_cnt_q  <= err_cnt_next;
		end
	end

	// Result register; counters are unchanged while a pop is in flight.
	always_ff @(posedge clk) begin
		if (cmd.load_now) begin
			read_valid_q     <= 1'b0;
			read_data_q      <= 8'd0;
			overflow_total_q <= drop_cnt_next;
			error_total_q    <= err_cnt_next;
		end else if (cmd.load_pop) begin
			read_valid_q     <= 1'b1;
			read_data_q      <= rd_byte_q;
			overflow_total_q <= drop_cnt_q;
			error_total_q    <= err_cnt_q;
		end
	end

	assign read_valid     = read_valid_q;
	assign read_data      = read_data_q;
	assign overflow_total = overflow_total_q;
	assign error_total    = error_total_q;

endmodule
`default_nettype wire

// ===== rtl/urxf_ctrl.sv =====
// Controller of the UART receive FIFO: handshakes, pop sequencing, datapath commands.
`default_nettype none
`include "uart_rx_fifo_with_error_counts_defines.svh"
module urxf_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire                   mode,
	input  wire                   data_ready,
	input  wire                   any_err,
	output logic                  m_tvalid,
	input  wire                   m_tready,
	input  wire urxf_pkg::urxf_stat_t stat,
	output urxf_pkg::urxf_cmd_t   cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_POP  = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic accept;
	logic is_rx;

	assign is_rx    = (mode == urxf_pkg::MODE_RX);
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd.push     = accept && is_rx && data_ready && !stat.full;
		cmd.drop     = accept && is_rx && data_ready && stat.full;
		cmd.err_inc  = accept && is_rx && any_err;
		cmd.pop      = accept && !is_rx && !stat.empty;
		cmd.load_now = accept && (is_rx || stat.empty);
		cmd.load_pop = (state_q == ST_POP);
	end

	always_comb begin
		case (state_q)
			ST_IDLE: state_d = cmd.pop ? ST_POP : ST_IDLE;
			ST_POP:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_now || cmd.load_pop) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	`URXF_ASSERT_NEXT(a_pop_leaves_out_free, clk, arst_n, cmd.pop, (state_q == ST_POP) && !out_valid_q, "pop started while result register busy")
	`URXF_ASSERT_NEXT(a_pop_yields_result, clk, arst_n, state_q == ST_POP, out_valid_q, "popped byte not presented")
	`URXF_ASSERT_NOW(a_one_ring_op, clk, arst_n, 1'b1, $countones({cmd.push, cmd.drop, cmd.pop}) <= 1, "more than one ring operation at once")

endmodule
`default_nettype wire

// ===== rtl/uart_rx_fifo_with_error_counts.sv =====
// Top level of the UART receive FIFO with overflow and line-error counters.
// A receive event or a read of an empty ring shows its result in the cycle after
// acceptance; a popped byte passes the ring's registered read port, then the result
// register. One transaction per cycle while m_tready holds; a pop stalls s_tready.
// Reset clears the pointers, both counters and all control state at once; the ring
// contents are not cleared and no clearing pass runs, so the block is ready right away.
`default_nettype none
module uart_rx_fifo_with_error_counts #(
	parameter int DEPTH = 512
) (
	input  wire          clk,
	input  wire          arst_n,
	// Slave side: receive events and read requests.
	input  wire          s_tvalid,
	output logic         s_tready,
	// s_tdata from bit 0: rx_byte[7:0], data_ready, overrun_flag, noise_flag,
	// framing_flag, parity_flag, then three zero bits.
	input  wire  [15:0]  s_tdata,
	// s_tuser: mode (0 = receive event, 1 = read request).
	input  wire          s_tuser,
	// Master side: one result per accepted transaction.
	output logic         m_tvalid,
	input  wire          m_tready,
	// m_tdata from bit 0: read_data[7:0], overflow_total[31:0], error_total[31:0].
	output logic [71:0]  m_tdata,
	// m_tuser: read_valid.
	output logic         m_tuser
);

	urxf_pkg::urxf_cmd_t  cmd;
	urxf_pkg::urxf_stat_t stat;

	logic [7:0]                 rx_byte;
	logic                       data_ready;
	logic                       any_err;
	logic                       read_valid;
	logic [7:0]                 read_data;
	logic [urxf_pkg::CNT_W-1:0] overflow_total;
	logic [urxf_pkg::CNT_W-1:0] error_total;

	// Unpack the slave transaction. The four line-error flags only matter as a group:
	// several at once still count as one error event.
	assign rx_byte    = s_tdata[7:0];
	assign data_ready = s_tdata[8];
	assign any_err    = s_tdata[9] | s_tdata[10] | s_tdata[11] | s_tdata[12];

	// The controller owns the handshakes and sequences the pop; the datapath
	// holds the ring, both pointers, the counters and the result register.
	urxf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.mode       (s_tuser),
		.data_ready (data_ready),
		.any_err    (any_err),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.stat       (stat),
		.cmd        (cmd)
	);

	urxf_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.rx_byte        (rx_byte),
		.stat           (stat),
		.read_valid     (read_valid),
		.read_data      (read_data),
		.overflow_total (overflow_total),
		.error_total    (error_total)
	);

	// Pack the master transaction.
	assign m_tdata = {error_total, overflow_total, read_data};
	assign m_tuser = read_valid;

endmodule
`default_nettype wire
